[hdl/cbts_pkg.sv]
// Shared constants and types for the clamped bilinear table sampler.
package cbts_pkg;

   localparam int TABLE_WIDTH  = 32;
   localparam int TABLE_HEIGHT = 32;
   localparam int ENTRY_COUNT  = TABLE_WIDTH * TABLE_HEIGHT;
   localparam int ADDR_W       = $clog2(ENTRY_COUNT);
   localparam int MAX_SIZE     = (TABLE_WIDTH > TABLE_HEIGHT) ? TABLE_WIDTH : TABLE_HEIGHT;
   localparam int IDX_W        = $clog2(MAX_SIZE);
   localparam int SIZE_W       = $clog2(MAX_SIZE + 1);
   localparam int COORD_W      = 17;
   localparam int G_W          = COORD_W + SIZE_W + 1;
   localparam int CODE_W       = 16;
   localparam int CHANNELS     = 3;

   localparam logic [23:0] GROUND_RADIUS_RESET = 24'd6360000;
   localparam logic [31:0] INV_SPAN_RESET      = 32'd42950;

   typedef enum logic [0:0] {
      CSR_GROUND_RADIUS = 1'b0,
      CSR_INV_SPAN      = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef logic [CHANNELS-1:0][CODE_W-1:0] texel_type;

   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      logic [15:0]      w;
   } cell_type;

endpackage

[hdl/clamped_bilinear_table_sampler.sv]
// Top level of the clamped bilinear table sampler: texel memories and sample pipeline.
//
// The block takes one word per clock: write and sample commands may be issued on every
// cycle and busy never rises. A sample returns its blended texel on rsp_strobe once it has
// passed stages s1 to s6 and the output register; a write returns nothing. The four
// neighbours of a sample are fetched in the same cycle from two copies of the texel table, each
// read at two addresses, and writes enter both copies at the same pipeline stage as reads,
// so commands take effect strictly in issue order. The receiver cannot stall the output.
module clamped_bilinear_table_sampler
   import cbts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [23:0]         req_radius,
   input  logic signed [15:0]  req_cos_sun,
   input  logic [4:0]          req_texel_col,
   input  logic [4:0]          req_texel_row,
   input  logic [15:0]         req_write_red,
   input  logic [15:0]         req_write_green,
   input  logic [15:0]         req_write_blue,
   output logic                rsp_strobe,
   output logic [15:0]         rsp_out_red,
   output logic [15:0]         rsp_out_green,
   output logic [15:0]         rsp_out_blue,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   function automatic cell_type locate(input logic [COORD_W-1:0] coord,
                                       input logic [SIZE_W-1:0] size);
      logic [G_W-1:0]    g;
      logic [G_W-17:0]   cp1;
      logic [G_W-17:0]   a;
      logic [G_W-17:0]   last;
      cell_type          res;
      g    = G_W'(coord) * G_W'(size) + G_W'(32768);
      cp1  = g[G_W-1:16];
      last = (G_W-16)'(size) - (G_W-16)'(1);
      a    = (cp1 == '0) ? '0 : cp1 - (G_W-16)'(1);
      res.lo = (a > last) ? last[IDX_W-1:0] : a[IDX_W-1:0];
      res.hi = (cp1 > last) ? last[IDX_W-1:0] : cp1[IDX_W-1:0];
      res.w  = g[15:0];
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input int row, input int col);
      logic [31:0] a;
      a = 32'(row * TABLE_WIDTH + col);
      return a[ADDR_W-1:0];
   endfunction

   function automatic logic [31:0] row_mix(input logic [15:0] c0, input logic [15:0] c1,
                                           input logic [15:0] w);
      logic [32:0] w1;
      logic [32:0] w0;
      logic [32:0] s;
      w1 = 33'(w);
      w0 = 33'h10000 - w1;
      s  = 33'(c0) * w0 + 33'(c1) * w1;
      return s[31:0];
   endfunction

   function automatic logic [47:0] col_mix(input logic [31:0] a, input logic [31:0] b,
                                           input logic [15:0] w);
      logic [48:0] w1;
      logic [48:0] w0;
      logic [48:0] s;
      w1 = 49'(w);
      w0 = 49'h10000 - w1;
      s  = 49'(a) * w0 + 49'(b) * w1;
      return s[47:0];
   endfunction

   logic accept;

   logic [23:0] ground_radius_ff;
   logic [31:0] inv_span_ff;

   logic              s1_sample_ff, s1_we_ff;
   logic [ADDR_W-1:0] s1_waddr_ff;
   texel_type         s1_wdata_ff;
   logic [23:0]       s1_diff_ff;
   logic [COORD_W-1:0] s1_u_ff;

   logic              s2_sample_ff, s2_we_ff;
   logic [ADDR_W-1:0] s2_waddr_ff;
   texel_type         s2_wdata_ff;
   logic [COORD_W-1:0] s2_u_ff;
   logic [55:0]       s2_prod_ff;

   logic              s3_sample_ff, s3_we_ff;
   logic [ADDR_W-1:0] s3_waddr_ff;
   texel_type         s3_wdata_ff;
   logic [ADDR_W-1:0] s3_addr_ff [4];
   logic [15:0]       s3_tx_ff, s3_ty_ff;

   logic              s4_sample_ff;
   texel_type         s4_texel_ff [4];
   logic [15:0]       s4_tx_ff, s4_ty_ff;

   logic              s5_sample_ff;
   logic [31:0]       s5_mix_a_ff [CHANNELS];
   logic [31:0]       s5_mix_b_ff [CHANNELS];
   logic [15:0]       s5_ty_ff;

   logic              s6_sample_ff;
   logic [47:0]       s6_sum_ff [CHANNELS];

   logic              rsp_strobe_ff;
   logic [15:0]       rsp_code_ff [CHANNELS];

   logic              s1_we_in;
   logic [23:0]       s1_diff_in;
   logic [COORD_W-1:0] s1_u_in;
   logic [39:0]       quot;
   logic [COORD_W-1:0] v_coord;
   cell_type          cell_x, cell_y;
   logic [15:0]       rsp_code_in [CHANNELS];

   texel_type texel_a_mem [ENTRY_COUNT];
   texel_type texel_b_mem [ENTRY_COUNT];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ground_radius_ff <= GROUND_RADIUS_RESET;
         inv_span_ff      <= INV_SPAN_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GROUND_RADIUS: ground_radius_ff <= csr_wdata[23:0];
            CSR_INV_SPAN:      inv_span_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_we_in   = accept && (cmd_type'(req_cmd) == CMD_WRITE)
                   && (int'(req_texel_col) < TABLE_WIDTH)
                   && (int'(req_texel_row) < TABLE_HEIGHT);
      s1_diff_in = (req_radius > ground_radius_ff) ? req_radius - ground_radius_ff : 24'd0;
      s1_u_in    = {1'b0, ~req_cos_sun[15], req_cos_sun[14:0]};
      quot       = s2_prod_ff[55:16];
      v_coord    = (quot > 40'h10000) ? 17'h10000 : quot[COORD_W-1:0];
      cell_x     = locate(s2_u_ff, SIZE_W'(TABLE_WIDTH));
      cell_y     = locate(v_coord, SIZE_W'(TABLE_HEIGHT));
      for (int c = 0; c < CHANNELS; c++) begin
         logic [48:0] r;
         r = 49'(s6_sum_ff[c]) + 49'h80000000;
         rsp_code_in[c] = (r[48:32] > 17'hFFFF) ? 16'hFFFF : r[47:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_sample_ff  <= 1'b0;
         s1_we_ff      <= 1'b0;
         s2_sample_ff  <= 1'b0;
         s2_we_ff      <= 1'b0;
         s3_sample_ff  <= 1'b0;
         s3_we_ff      <= 1'b0;
         s4_sample_ff  <= 1'b0;
         s5_sample_ff  <= 1'b0;
         s6_sample_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_sample_ff  <= accept && (cmd_type'(req_cmd) == CMD_SAMPLE);
         s1_we_ff      <= s1_we_in;
         s2_sample_ff  <= s1_sample_ff;
         s2_we_ff      <= s1_we_ff;
         s3_sample_ff  <= s2_sample_ff;
         s3_we_ff      <= s2_we_ff;
         s4_sample_ff  <= s3_sample_ff;
         s5_sample_ff  <= s4_sample_ff;
         s6_sample_ff  <= s5_sample_ff;
         rsp_strobe_ff <= s6_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_waddr_ff <= addr_of(int'(req_texel_row), int'(req_texel_col));
      s1_wdata_ff <= {req_write_blue, req_write_green, req_write_red};
      s1_diff_ff  <= s1_diff_in;
      s1_u_ff     <= s1_u_in;

      s2_waddr_ff <= s1_waddr_ff;
      s2_wdata_ff <= s1_wdata_ff;
      s2_u_ff     <= s1_u_ff;
      s2_prod_ff  <= 56'(s1_diff_ff) * 56'(inv_span_ff);

      s3_waddr_ff   <= s2_waddr_ff;
      s3_wdata_ff   <= s2_wdata_ff;
      s3_addr_ff[0] <= addr_of(int'(cell_y.lo), int'(cell_x.lo));
      s3_addr_ff[1] <= addr_of(int'(cell_y.lo), int'(cell_x.hi));
      s3_addr_ff[2] <= addr_of(int'(cell_y.hi), int'(cell_x.lo));
      s3_addr_ff[3] <= addr_of(int'(cell_y.hi), int'(cell_x.hi));
      s3_tx_ff      <= cell_x.w;
      s3_ty_ff      <= cell_y.w;

      s4_tx_ff <= s3_tx_ff;
      s4_ty_ff <= s3_ty_ff;

      for (int c = 0; c < CHANNELS; c++) begin
         s5_mix_a_ff[c] <= row_mix(s4_texel_ff[0][c], s4_texel_ff[1][c], s4_tx_ff);
         s5_mix_b_ff[c] <= row_mix(s4_texel_ff[2][c], s4_texel_ff[3][c], s4_tx_ff);
         s6_sum_ff[c]   <= col_mix(s5_mix_a_ff[c], s5_mix_b_ff[c], s5_ty_ff);
         rsp_code_ff[c] <= rsp_code_in[c];
      end
      s5_ty_ff <= s4_ty_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_we_ff) begin
         texel_a_mem[s3_waddr_ff] <= s3_wdata_ff;
         texel_b_mem[s3_waddr_ff] <= s3_wdata_ff;
      end
      s4_texel_ff[0] <= texel_a_mem[s3_addr_ff[0]];
      s4_texel_ff[1] <= texel_a_mem[s3_addr_ff[1]];
      s4_texel_ff[2] <= texel_b_mem[s3_addr_ff[2]];
      s4_texel_ff[3] <= texel_b_mem[s3_addr_ff[3]];
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_red   = rsp_code_ff[0];
   assign rsp_out_green = rsp_code_ff[1];
   assign rsp_out_blue  = rsp_code_ff[2];

endmodule
